// ===== hdl/ipv4dq_pkg.sv =====
package ipv4dq_pkg;

  // Character codes used by the parser
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DIG0 = 8'h30;
  localparam logic [7:0] CH_DIG9 = 8'h39;

  // Largest value an octet may take
  localparam logic [11:0] OCTET_MAX = 12'd255;

  // Index of the last octet, which ends on NUL instead of a dot
  localparam logic [1:0] LAST_OCTET = 2'd3;

  // One result item
  typedef struct packed {
    logic        parse_ok;
    logic [31:0] address;
  } result_t;

endpackage

// ===== hdl/ipv4dq_char_if.sv =====
interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== hdl/ipv4dq_result_if.sv =====
interface ipv4dq_result_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [31:0] address;

  modport source (output valid, output parse_ok, output address, input ready);
  modport sink   (input valid, input parse_ok, input address, output ready);
endinterface

// ===== hdl/ipv4dq_parse.sv =====
module ipv4dq_parse
  import ipv4dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_code,
  output logic       emit,
  output result_t    result
);

  logic [7:0]  octet_value, octet_value_next;
  logic [1:0]  octet_index, octet_index_next;
  logic        digit_seen, digit_seen_next;
  logic [23:0] octets_done, octets_done_next;
  logic        skipping_to_end, skipping_to_end_next;

  logic        is_digit;
  logic [3:0]  digit_val;
  logic [11:0] acc;
  logic [7:0]  term;

  // Digit decode and value*10 + digit
  always_comb begin
    is_digit  = (char_code >= CH_DIG0) && (char_code <= CH_DIG9);
    digit_val = char_code[3:0];
    acc       = {1'b0, octet_value, 3'b000} + {3'b000, octet_value, 1'b0}
              + {8'd0, digit_val};
    term      = (octet_index == LAST_OCTET) ? CH_NUL : CH_DOT;
  end

  // One parse step per character
  always_comb begin
    octet_value_next     = octet_value;
    octet_index_next     = octet_index;
    digit_seen_next      = digit_seen;
    octets_done_next     = octets_done;
    skipping_to_end_next = skipping_to_end;
    emit                 = 1'b0;
    result               = '0;

    if (skipping_to_end) begin
      // discard up to and including the next NUL
      if (char_code == CH_NUL) begin
        skipping_to_end_next = 1'b0;
      end
    end else if (is_digit && (acc <= OCTET_MAX)) begin
      octet_value_next = acc[7:0];
      digit_seen_next  = 1'b1;
    end else if (is_digit || (char_code != term) || !digit_seen) begin
      // failure: octet overflow, bad character or empty octet
      octet_value_next     = '0;
      octet_index_next     = '0;
      digit_seen_next      = 1'b0;
      octets_done_next     = '0;
      skipping_to_end_next = (char_code != CH_NUL);
      emit                 = 1'b1;
    end else if (octet_index == LAST_OCTET) begin
      octet_value_next = '0;
      octet_index_next = '0;
      digit_seen_next  = 1'b0;
      octets_done_next = '0;
      emit             = 1'b1;
      result.parse_ok  = 1'b1;
      result.address   = {octets_done, octet_value};
    end else begin
      octets_done_next = {octets_done[15:0], octet_value};
      octet_index_next = octet_index + 2'd1;
      octet_value_next = '0;
      digit_seen_next  = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      octet_value     <= '0;
      octet_index     <= '0;
      digit_seen      <= 1'b0;
      octets_done     <= '0;
      skipping_to_end <= 1'b0;
    end else if (step) begin
      octet_value     <= octet_value_next;
      octet_index     <= octet_index_next;
      digit_seen      <= digit_seen_next;
      octets_done     <= octets_done_next;
      skipping_to_end <= skipping_to_end_next;
    end
  end

endmodule

// ===== hdl/ipv4dq_ipv4_out.sv =====
module ipv4dq_ipv4_out
  import ipv4dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    free,
  ipv4dq_result_if.source result_out
);

  logic    res_valid;
  result_t res_data;

  // Register can take a new item when empty or being drained this cycle
  assign free = !res_valid || result_out.ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_data <= result;
    end
  end

  assign result_out.valid    = res_valid;
  assign result_out.parse_ok = res_data.parse_ok;
  assign result_out.address  = res_data.address;

endmodule

// ===== hdl/ipv4_dotted_quad_parser.sv =====
// Strict IPv4 dotted-quad parser. Send one ASCII character per item, the
// string closed by a NUL (zero) character. The block emits one result per
// string: parse_ok=1 with the 32-bit address (first octet in bits 31..24)
// on the closing NUL, or parse_ok=0 with address zero at the first fault
// (bad character, empty octet, octet above 255, NUL before the fourth
// octet). After a fault the rest of the string up to its NUL is dropped
// silently. Characters are taken at one per clock: a character sits in an
// input register while the parse step updates the state, and
// the result goes into an output register, so a new character is accepted
// every cycle unless the result register is full and not being taken.
module ipv4_dotted_quad_parser
  import ipv4dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ipv4dq_char_if.sink      char_in,
  ipv4dq_result_if.source  result_out
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       advance;
  logic       out_free;
  logic       emit;
  result_t    step_result;

  // Input stage moves on whenever the result register has room
  assign advance       = in_valid && out_free;
  assign char_in.ready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      in_char <= char_in.char_code;
    end
  end

  ipv4dq_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (in_char),
    .emit      (emit),
    .result    (step_result)
  );

  ipv4dq_ipv4_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && emit),
    .result     (step_result),
    .free       (out_free),
    .result_out (result_out)
  );

endmodule
